// ===== rtl/core/bpc_pkg.sv =====
// ============================================================================
// bpc_pkg
// Shared types and constants for the pressure/temperature compensation block.
// ============================================================================
package bpc_pkg;

  // Restoring divider geometry: dividend bits, divisor bits, sideband bits
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 18;
  localparam int DIV_SW = 45;

  // Compensation constants
  localparam logic [11:0]        B6_OFS    = 12'd4000;
  localparam logic [11:0]        C_SQ      = 12'd3038;
  localparam logic signed [13:0] C_LIN     = -14'sd7357;
  localparam logic [11:0]        C_PR_OFS  = 12'd3791;
  localparam logic [15:0]        B7_SCALE  = 16'd50000;
  localparam logic [15:0]        B4_OFS    = 16'd32768;
  localparam logic [16:0]        PRESS_MAX = 17'd131071;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CAL_A = 2'd0,
    REG_CAL_B = 2'd1,
    REG_CAL_C = 2'd2,
    REG_OSS   = 2'd3
  } cfg_idx_t;

  // Unpacked calibration coefficients
  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } cal_t;

  // One divider stage: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [DIV_DW-1:0] rem;
    logic [DIV_NW-1:0] work;
  } div_st_t;

  // Sideband through the temperature divider
  typedef struct packed {
    logic signed [18:0] x1;
    logic [23:0]        raw_press;
    logic               neg;
    logic               err;
  } tside_t;

  // Sideband through the pressure divider
  typedef struct packed {
    logic [26:0]        pad;
    logic signed [15:0] temp;
    logic               big;
    logic               err;
  } pside_t;

endpackage

// ===== rtl/core/bpc_div.sv =====
// ============================================================================
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ============================================================================
module bpc_div import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_NW-1:0] in_num,
  input  logic [DIV_DW-1:0] in_den,
  input  logic [DIV_SW-1:0] in_side,
  output logic              out_valid,
  output logic [DIV_NW-1:0] out_quot,
  output logic [DIV_SW-1:0] out_side
);

  div_st_t           st_r   [DIV_NW];
  div_st_t           st_nxt [DIV_NW];
  logic [DIV_DW-1:0] den_r  [DIV_NW];
  logic [DIV_SW-1:0] side_r [DIV_NW];
  logic [DIV_NW-1:0] vld_r;

  // One trial subtraction: shift in the next dividend bit, keep if it fits
  function automatic div_st_t div_step(input logic [DIV_DW-1:0] rem,
                                       input logic [DIV_NW-1:0] work,
                                       input logic [DIV_DW-1:0] den);
    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    logic            ge;
    div_st_t         res;
    trial    = {rem, work[DIV_NW-1]};
    diff     = trial - {1'b0, den};
    ge       = (trial >= {1'b0, den});
    res.rem  = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    res.work = {work[DIV_NW-2:0], ge};
    return res;
  endfunction

  // Stage next values
  always_comb begin
    st_nxt[0] = div_step('0, in_num, in_den);
    for (int k = 1; k < DIV_NW; k++) begin
      st_nxt[k] = div_step(st_r[k-1].rem, st_r[k-1].work, den_r[k-1]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_NW-2:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= st_nxt[0];
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int k = 1; k < DIV_NW; k++) begin
        st_r[k]   <= st_nxt[k];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[DIV_NW-1];
  assign out_quot  = st_r[DIV_NW-1].work;
  assign out_side  = side_r[DIV_NW-1];

endmodule

// ===== rtl/core/bpc_temp.sv =====
// ============================================================================
// bpc_temp
// Temperature front end: forms X1 and the operands of the temperature divide.
// ============================================================================
module bpc_temp import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  cal_t              cal,
  input  logic              in_valid,
  input  logic [15:0]       in_raw_temp,
  input  logic [23:0]       in_raw_press,
  output logic              div_valid,
  output logic [DIV_NW-1:0] div_num,
  output logic [DIV_DW-1:0] div_den,
  output logic [DIV_SW-1:0] div_side
);

  logic signed [16:0] ut_d;
  logic signed [33:0] prod_nxt;
  logic signed [33:0] prod_r;
  logic [23:0]        press1_r;
  logic               vld1_r;

  logic signed [33:0] x1_full;
  logic signed [18:0] x1;
  logic signed [18:0] den;
  logic [18:0]        den_abs;
  logic [15:0]        mc_abs;
  tside_t             side_nxt;

  logic               vld2_r;
  logic [DIV_NW-1:0]  num_r;
  logic [DIV_DW-1:0]  den_r;
  tside_t             side_r;

  // Stage 1: (UT - AC6) * AC5
  assign ut_d     = $signed({1'b0, in_raw_temp}) - $signed({1'b0, cal.ac6});
  assign prod_nxt = ut_d * $signed({1'b0, cal.ac5});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      press1_r <= in_raw_press;
    end
  end

  // Stage 2: X1, divisor X1+MD, and sign-magnitude split of MC*2048 / divisor
  always_comb begin
    x1_full            = prod_r >>> 15;
    x1                 = x1_full[18:0];
    den                = x1 + $signed({{3{cal.md[15]}}, cal.md});
    den_abs            = den[18] ? (~den + 19'd1) : den;
    mc_abs             = cal.mc[15] ? (~cal.mc + 16'd1) : cal.mc;
    side_nxt.x1        = x1;
    side_nxt.raw_press = press1_r;
    side_nxt.neg       = cal.mc[15] ^ den[18];
    side_nxt.err       = (den == 19'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= {5'b0, mc_abs, 11'b0};
      den_r  <= den_abs[17:0];
      side_r <= side_nxt;
    end
  end

  assign div_valid = vld2_r;
  assign div_num   = num_r;
  assign div_den   = den_r;
  assign div_side  = side_r;

endmodule

// ===== rtl/core/bpc_pmid.sv =====
// ============================================================================
// bpc_pmid
// Middle section: B5, temperature, B6 terms, B3, B4, B7 and divide operands.
// ============================================================================
module bpc_pmid import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  cal_t              cal,
  input  logic              in_valid,
  input  logic [DIV_NW-1:0] in_quot,
  input  logic [DIV_SW-1:0] in_side,
  output logic              div_valid,
  output logic [DIV_NW-1:0] div_num,
  output logic [DIV_DW-1:0] div_den,
  output logic [DIV_SW-1:0] div_side
);

  tside_t             tside;
  logic signed [27:0] x2q;
  logic signed [28:0] b5_nxt;

  // stage valid bits, stage 3 .. stage 11
  logic [8:0]         vld_r;

  // stage 3
  logic signed [28:0] b5_r;
  logic               err3_r;
  logic [23:0]        press3_r;
  // stage 4
  logic signed [29:0] t_sum;
  logic signed [29:0] t_sh;
  logic signed [15:0] t_nxt;
  logic signed [28:0] b6_nxt;
  logic signed [15:0] t4_r;
  logic signed [28:0] b6_r;
  logic               err4_r;
  logic [23:0]        press4_r;
  // stage 5
  logic signed [57:0] sq_r;
  logic signed [44:0] m2_r;
  logic signed [44:0] m3_r;
  logic signed [15:0] t5_r;
  logic               err5_r;
  logic [23:0]        press5_r;
  // stage 6
  logic signed [57:0] sq_sh;
  logic signed [45:0] sqs;
  logic signed [44:0] m2_sh;
  logic signed [44:0] m3_sh;
  logic signed [61:0] pb2_r;
  logic signed [61:0] pb1_r;
  logic signed [33:0] x2a_r;
  logic signed [31:0] x1b_r;
  logic signed [15:0] t6_r;
  logic               err6_r;
  logic [23:0]        press6_r;
  // stage 7
  logic signed [61:0] pb2_sh;
  logic signed [61:0] pb1_sh;
  logic signed [51:0] x3a_nxt;
  logic signed [47:0] x3b_sum;
  logic signed [47:0] x3b_sh;
  logic signed [51:0] x3a_r;
  logic signed [45:0] x3b_r;
  logic signed [15:0] t7_r;
  logic               err7_r;
  logic [23:0]        press7_r;
  // stage 8
  logic signed [52:0] b3_base;
  logic signed [55:0] b3_scl;
  logic signed [56:0] b3_sum;
  logic signed [56:0] b3_sh;
  logic signed [46:0] b4_arg;
  logic [47:0]        b4_full;
  logic signed [54:0] b3_r;
  logic [31:0]        b4p_r;
  logic signed [15:0] t8_r;
  logic               err8_r;
  logic [23:0]        press8_r;
  // stage 9
  logic [3:0]         up_shamt;
  logic [23:0]        up;
  logic [16:0]        b4_nxt;
  logic [16:0]        b4_r;
  logic [31:0]        diff_r;
  logic signed [15:0] t9_r;
  logic               err9_r;
  // stage 10
  logic [15:0]        b7_k;
  logic [47:0]        b7_full;
  logic [31:0]        b7_r;
  logic [16:0]        b4_10_r;
  logic signed [15:0] t10_r;
  logic               err10_r;
  // stage 11
  pside_t             pside_nxt;
  logic [DIV_NW-1:0]  num_r;
  logic [DIV_DW-1:0]  den_r;
  pside_t             side_r;

  assign tside = tside_t'(in_side);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:0], in_valid};
    end
  end

  // Stage 3: apply quotient sign, B5 = X1 + X2
  always_comb begin
    x2q    = tside.neg ? -$signed({1'b0, in_quot[26:0]}) : $signed({1'b0, in_quot[26:0]});
    b5_nxt = $signed({x2q[27], x2q}) + $signed({{10{tside.x1[18]}}, tside.x1});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b5_r     <= b5_nxt;
      err3_r   <= tside.err;
      press3_r <= tside.raw_press;
    end
  end

  // Stage 4: rounded temperature with saturation, B6
  always_comb begin
    t_sum = $signed({b5_r[28], b5_r}) + 30'sd8;
    t_sh  = t_sum >>> 4;
    priority if (t_sh > 30'sd32767) begin
      t_nxt = 16'sh7FFF;
    end else if (t_sh < -30'sd32768) begin
      t_nxt = -16'sh8000;
    end else begin
      t_nxt = t_sh[15:0];
    end
    b6_nxt = b5_r - $signed({17'b0, B6_OFS});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_r     <= t_nxt;
      b6_r     <= b6_nxt;
      err4_r   <= err3_r;
      press4_r <= press3_r;
    end
  end

  // Stage 5: B6 squared, AC2*B6, AC3*B6
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= b6_r * b6_r;
      m2_r     <= b6_r * $signed(cal.ac2);
      m3_r     <= b6_r * $signed(cal.ac3);
      t5_r     <= t4_r;
      err5_r   <= err4_r;
      press5_r <= press4_r;
    end
  end

  // Stage 6: scale square by B2 and B1, shift AC2*B6 and AC3*B6
  always_comb begin
    sq_sh = sq_r >>> 12;
    sqs   = sq_sh[45:0];
    m2_sh = m2_r >>> 11;
    m3_sh = m3_r >>> 13;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb2_r    <= sqs * $signed(cal.b2);
      pb1_r    <= sqs * $signed(cal.b1);
      x2a_r    <= m2_sh[33:0];
      x1b_r    <= m3_sh[31:0];
      t6_r     <= t5_r;
      err6_r   <= err5_r;
      press6_r <= press5_r;
    end
  end

  // Stage 7: X3 for B3 and X3 for B4
  always_comb begin
    pb2_sh  = pb2_r >>> 11;
    pb1_sh  = pb1_r >>> 16;
    x3a_nxt = $signed({pb2_sh[50], pb2_sh[50:0]}) + $signed({{18{x2a_r[33]}}, x2a_r});
    x3b_sum = $signed({{2{pb1_sh[45]}}, pb1_sh[45:0]})
            + $signed({{16{x1b_r[31]}}, x1b_r}) + 48'sd2;
    x3b_sh  = x3b_sum >>> 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3a_r    <= x3a_nxt;
      x3b_r    <= x3b_sh[45:0];
      t7_r     <= t6_r;
      err7_r   <= err6_r;
      press7_r <= press6_r;
    end
  end

  // Stage 8: B3 with oversampling scale, AC4 product for B4
  always_comb begin
    b3_base = $signed({{35{cal.ac1[15]}}, cal.ac1, 2'b00}) + $signed({x3a_r[51], x3a_r});
    b3_scl  = $signed({{3{b3_base[52]}}, b3_base}) <<< cal.oss;
    b3_sum  = $signed({b3_scl[55], b3_scl}) + 57'sd2;
    b3_sh   = b3_sum >>> 2;
    b4_arg  = $signed({x3b_r[45], x3b_r}) + $signed({31'b0, B4_OFS});
    b4_full = b4_arg[31:0] * cal.ac4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_r     <= b3_sh[54:0];
      b4p_r    <= b4_full[31:0];
      t8_r     <= t7_r;
      err8_r   <= err7_r;
      press8_r <= press7_r;
    end
  end

  // Stage 9: B4, zero check, UP - B3 modulo 2^32
  always_comb begin
    up_shamt = 4'd8 - {2'b0, cal.oss};
    up       = press8_r >> up_shamt;
    b4_nxt   = b4p_r[31:15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b4_r   <= b4_nxt;
      diff_r <= {8'b0, up} - b3_r[31:0];
      t9_r   <= t8_r;
      err9_r <= err8_r | (b4_nxt == 17'd0);
    end
  end

  // Stage 10: B7 modulo 2^32
  always_comb begin
    b7_k    = B7_SCALE >> cal.oss;
    b7_full = diff_r * b7_k;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b7_r    <= b7_full[31:0];
      b4_10_r <= b4_r;
      t10_r   <= t9_r;
      err10_r <= err9_r;
    end
  end

  // Stage 11: pick dividend form by the top bit of B7
  always_comb begin
    pside_nxt.pad  = '0;
    pside_nxt.temp = t10_r;
    pside_nxt.big  = b7_r[31];
    pside_nxt.err  = err10_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= b7_r[31] ? b7_r : {b7_r[30:0], 1'b0};
      den_r  <= {1'b0, b4_10_r};
      side_r <= pside_nxt;
    end
  end

  assign div_valid = vld_r[8];
  assign div_num   = num_r;
  assign div_den   = den_r;
  assign div_side  = side_r;

endmodule

// ===== rtl/core/bpc_pback.sv =====
// ============================================================================
// bpc_pback
// Pressure back end: final polynomial correction, saturation, output word.
// ============================================================================
module bpc_pback import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_NW-1:0] in_quot,
  input  logic [DIV_SW-1:0] in_side,
  output logic              out_valid,
  output logic signed [15:0] out_temp_tenths,
  output logic [16:0]       out_press_pa,
  output logic              out_div_error
);

  pside_t             pside;
  logic [2:0]         vld_r;

  // stage 12
  logic [32:0]        p12_r;
  logic signed [15:0] t12_r;
  logic               err12_r;
  // stage 13
  logic [24:0]        pa;
  logic [49:0]        sq2_r;
  logic signed [47:0] m_r;
  logic [32:0]        p13_r;
  logic signed [15:0] t13_r;
  logic               err13_r;
  // stage 14
  logic [61:0]        x1_full;
  logic signed [47:0] m_sh;
  logic [45:0]        x1f_r;
  logic signed [31:0] x2f_r;
  logic [32:0]        p14_r;
  logic signed [15:0] t14_r;
  logic               err14_r;
  // stage 15
  logic signed [47:0] corr_sum;
  logic signed [47:0] corr_sh;
  logic signed [48:0] pr;
  logic [16:0]        pr_sat;
  logic               vld_out_r;
  logic signed [15:0] temp_out_r;
  logic [16:0]        press_out_r;
  logic               err_out_r;

  assign pside = pside_t'(in_side);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[1:0], in_valid};
      vld_out_r <= vld_r[2];
    end
  end

  // Stage 12: undo the halved dividend for large B7
  always_ff @(posedge clk) begin
    if (en) begin
      p12_r   <= pside.big ? {in_quot, 1'b0} : {1'b0, in_quot};
      t12_r   <= pside.temp;
      err12_r <= pside.err;
    end
  end

  // Stage 13: (P>>8)^2 and -7357*P
  assign pa = p12_r[32:8];

  always_ff @(posedge clk) begin
    if (en) begin
      sq2_r   <= pa * pa;
      m_r     <= $signed({1'b0, p12_r}) * C_LIN;
      p13_r   <= p12_r;
      t13_r   <= t12_r;
      err13_r <= err12_r;
    end
  end

  // Stage 14: scale the square, shift the linear term
  always_comb begin
    x1_full = sq2_r * C_SQ;
    m_sh    = m_r >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1f_r   <= x1_full[61:16];
      x2f_r   <= m_sh[31:0];
      p14_r   <= p13_r;
      t14_r   <= t13_r;
      err14_r <= err13_r;
    end
  end

  // Stage 15: add correction, saturate, zero the word on a divide error
  always_comb begin
    corr_sum = $signed({2'b0, x1f_r}) + $signed({{16{x2f_r[31]}}, x2f_r})
             + $signed({36'b0, C_PR_OFS});
    corr_sh  = corr_sum >>> 4;
    pr       = $signed({16'b0, p14_r}) + $signed({corr_sh[47], corr_sh});
    priority if (pr < 49'sd0) begin
      pr_sat = 17'd0;
    end else if (pr > $signed({32'b0, PRESS_MAX})) begin
      pr_sat = PRESS_MAX;
    end else begin
      pr_sat = pr[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_out_r  <= err14_r ? 16'sd0 : t14_r;
      press_out_r <= err14_r ? 17'd0 : pr_sat;
      err_out_r   <= err14_r;
    end
  end

  assign out_valid       = vld_out_r;
  assign out_temp_tenths = temp_out_r;
  assign out_press_pa    = press_out_r;
  assign out_div_error   = err_out_r;

endmodule

// ===== rtl/core/barometric_pressure_compensation_top.sv =====
// ============================================================================
// barometric_pressure_compensation_top
// Integer temperature and pressure compensation for a barometric sensor.
// ============================================================================
// Input channel in_*: one word per reading (raw temperature word and raw
// 24-bit pressure). Result channel out_*: temperature in 0.1 C, pressure in
// Pa, and a divide-error flag; both results read zero when a divisor was 0.
// Both channels move a word at a clock edge with valid high and stall low.
// Calibration words and the oversampling setting are written on the cfg_*
// port; the user must do so only while no reading is in flight, as the
// block itself does not enforce it. One word is accepted every cycle while
// in_stall is low. The two 32-stage pipelined dividers (one quotient bit per
// stage) and the multiply stages around them make up the pipeline.
// The whole pipeline advances together: while a result waits under out_stall,
// every stage holds and in_stall is raised; bubbles are carried, not dropped.
// Reset (rst_n low, synchronous) clears all valid bits and sets the
// calibration registers and the oversampling setting to zero.
// ============================================================================
module barometric_pressure_compensation_top import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_raw_temp,
  input  logic [23:0]        in_raw_press,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_temp_tenths,
  output logic [16:0]        out_press_pa,
  output logic               out_div_error
);

  logic [63:0]       cal_a_r;
  logic [63:0]       cal_b_r;
  logic [47:0]       cal_c_r;
  logic [1:0]        oss_r;
  cal_t              cal;
  logic              en;

  logic              d1_in_valid;
  logic [DIV_NW-1:0] d1_in_num;
  logic [DIV_DW-1:0] d1_in_den;
  logic [DIV_SW-1:0] d1_in_side;
  logic              d1_out_valid;
  logic [DIV_NW-1:0] d1_out_quot;
  logic [DIV_SW-1:0] d1_out_side;

  logic              d2_in_valid;
  logic [DIV_NW-1:0] d2_in_num;
  logic [DIV_DW-1:0] d2_in_den;
  logic [DIV_SW-1:0] d2_in_side;
  logic              d2_out_valid;
  logic [DIV_NW-1:0] d2_out_quot;
  logic [DIV_SW-1:0] d2_out_side;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CAL_A: cal_a_r <= cfg_data;
        REG_CAL_B: cal_b_r <= cfg_data;
        REG_CAL_C: cal_c_r <= cfg_data[47:0];
        REG_OSS:   oss_r   <= cfg_data[1:0];
        default:   oss_r   <= oss_r;
      endcase
    end
  end

  // Unpack coefficients
  always_comb begin
    cal.ac1 = cal_a_r[15:0];
    cal.ac2 = cal_a_r[31:16];
    cal.ac3 = cal_a_r[47:32];
    cal.ac4 = cal_a_r[63:48];
    cal.ac5 = cal_b_r[15:0];
    cal.ac6 = cal_b_r[31:16];
    cal.b1  = cal_b_r[47:32];
    cal.b2  = cal_b_r[63:48];
    cal.mc  = cal_c_r[31:16];
    cal.md  = cal_c_r[47:32];
    cal.oss = oss_r;
  end

  // Hold every stage while the output word is stalled
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  bpc_temp u_temp (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .cal          (cal),
    .in_valid     (in_valid),
    .in_raw_temp  (in_raw_temp),
    .in_raw_press (in_raw_press),
    .div_valid    (d1_in_valid),
    .div_num      (d1_in_num),
    .div_den      (d1_in_den),
    .div_side     (d1_in_side)
  );

  bpc_div u_div_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d1_in_valid),
    .in_num    (d1_in_num),
    .in_den    (d1_in_den),
    .in_side   (d1_in_side),
    .out_valid (d1_out_valid),
    .out_quot  (d1_out_quot),
    .out_side  (d1_out_side)
  );

  bpc_pmid u_pmid (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cal       (cal),
    .in_valid  (d1_out_valid),
    .in_quot   (d1_out_quot),
    .in_side   (d1_out_side),
    .div_valid (d2_in_valid),
    .div_num   (d2_in_num),
    .div_den   (d2_in_den),
    .div_side  (d2_in_side)
  );

  bpc_div u_div_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d2_in_valid),
    .in_num    (d2_in_num),
    .in_den    (d2_in_den),
    .in_side   (d2_in_side),
    .out_valid (d2_out_valid),
    .out_quot  (d2_out_quot),
    .out_side  (d2_out_side)
  );

  bpc_pback u_pback (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (d2_out_valid),
    .in_quot         (d2_out_quot),
    .in_side         (d2_out_side),
    .out_valid       (out_valid),
    .out_temp_tenths (out_temp_tenths),
    .out_press_pa    (out_press_pa),
    .out_div_error   (out_div_error)
  );

endmodule
